// ----- design/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int CmdWidth   = 1;
   localparam int CharWidth  = 8;
   localparam int ColorWidth = 4;
   localparam int RowWidth   = 5;
   localparam int ColWidth   = 7;
   localparam int CellWidth  = 16;

   localparam logic [CmdWidth-1:0] CMD_PUT  = 1'b0;
   localparam logic [CmdWidth-1:0] CMD_READ = 1'b1;

   localparam logic [CharWidth-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CharWidth-1:0] CH_BACKSPACE = 8'd8;

   localparam logic [CellWidth-1:0] BLANK_CELL = 16'h0020;
   localparam logic [CellWidth-1:0] EMPTY_CELL = 16'h0000;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_SCROLL,
      ST_DONE
   } state_type;

endpackage

// ----- design/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Text console with a cell buffer in one synchronous memory and a cursor.
// ----------------------------------------------------------------------------
// Usage: one command per transfer on the req_ channel. A put writes a
// printable character at the cursor and advances it, or handles newline and
// backspace; a read returns one cell. Every command gives one transfer on
// the rsp_ channel with the cursor after the command.
// Sequence: a put goes from EXEC to DONE, a read inside the screen through
// FETCH, and a put that scrolls through SCROLL before DONE. Scrolling
// advances a top-row pointer into the memory and clears one row, one cell
// a cycle through the single write port; rows are never copied.
// The sequencer takes one command at a time: req_stall is high outside
// IDLE, so a new request is taken only once the last result has left
// DONE for the rsp_ register.
// Reset: the cursor returns to the origin and a clearing pass writes zero to
// all ROWS * 2**clog2(COLS) memory words while req_stall stays high.
// Stall: a finished result waits in the rsp_ register; the next request is
// taken meanwhile and its result waits until the pending one is transferred.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tcw_pkg::CmdWidth-1:0]       req_cmd,
   input  logic [tcw_pkg::CharWidth-1:0]      req_char_code,
   input  logic [tcw_pkg::ColorWidth-1:0]     req_back_color,
   input  logic [tcw_pkg::ColorWidth-1:0]     req_fore_color,
   input  logic [tcw_pkg::RowWidth-1:0]       req_read_row,
   input  logic [tcw_pkg::ColWidth-1:0]       req_read_col,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tcw_pkg::ColWidth-1:0]       rsp_cursor_col,
   output logic [tcw_pkg::RowWidth-1:0]       rsp_cursor_row,
   output logic [tcw_pkg::CellWidth-1:0]      rsp_cell_value,
   output logic                               rsp_did_scroll
);
   import tcw_pkg::*;

   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = ROWS << CW;
   localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
   localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
   localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

   logic [CellWidth-1:0] screen_mem [DEPTH];

   state_type state_ff, state_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [RW-1:0] top_ff, top_in;
   logic [AW-1:0] cnt_ff, cnt_in;

   logic [CmdWidth-1:0]   item_cmd_ff;
   logic [CharWidth-1:0]  item_char_ff;
   logic [ColorWidth-1:0] item_back_ff;
   logic [ColorWidth-1:0] item_fore_ff;
   logic [RowWidth-1:0]   item_row_ff;
   logic [ColWidth-1:0]   item_col_ff;

   logic [CellWidth-1:0] cell_ff, cell_in;
   logic                 scroll_ff, scroll_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ColWidth-1:0]  rsp_col_ff, rsp_col_in;
   logic [RowWidth-1:0]  rsp_row_ff, rsp_row_in;
   logic [CellWidth-1:0] rsp_cell_ff, rsp_cell_in;
   logic                 rsp_scroll_ff, rsp_scroll_in;

   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [CellWidth-1:0] mem_wdata, mem_rdata_ff;

   logic                 req_take;
   logic                 rsp_free;
   logic                 read_in_range;
   logic [CW-1:0]        bs_col;
   logic [RW-1:0]        bs_row;

   function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                              input logic [RW-1:0] top);
      logic [RW:0] sum;
      sum = {1'b0, lrow} + {1'b0, top};
      if (sum >= (RW+1)'(ROWS)) begin
         sum = sum - (RW+1)'(ROWS);
      end
      return sum[RW-1:0];
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign read_in_range = (32'(item_row_ff) < ROWS) && (32'(item_col_ff) < COLS);

   always_comb begin
      bs_col = cur_col_ff;
      bs_row = cur_row_ff;
      if (cur_col_ff != '0) begin
         bs_col = cur_col_ff - 1'b1;
      end else if (cur_row_ff != '0) begin
         bs_col = COL_LAST;
         bs_row = cur_row_ff - 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      top_in        = top_ff;
      cnt_in        = cnt_ff;
      cell_in       = cell_ff;
      scroll_in     = scroll_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_scroll_in = rsp_scroll_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = EMPTY_CELL;
      mem_re        = 1'b0;
      mem_raddr     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_LAST) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cell_in   = EMPTY_CELL;
            scroll_in = 1'b0;
            state_in  = ST_DONE;
            priority if (item_cmd_ff == CMD_READ) begin
               if (read_in_range) begin
                  mem_re    = 1'b1;
                  mem_raddr = {phys_row(RW'(item_row_ff), top_ff), CW'(item_col_ff)};
                  state_in  = ST_FETCH;
               end
            end else if (item_char_ff == CH_BACKSPACE) begin
               cur_col_in = bs_col;
               cur_row_in = bs_row;
               mem_we     = 1'b1;
               mem_waddr  = {phys_row(bs_row, top_ff), bs_col};
               mem_wdata  = BLANK_CELL;
            end else begin
               if (item_char_ff != CH_NEWLINE) begin
                  mem_we    = 1'b1;
                  mem_waddr = {phys_row(cur_row_ff, top_ff), cur_col_ff};
                  mem_wdata = {item_back_ff, item_fore_ff, item_char_ff};
               end
               if ((item_char_ff == CH_NEWLINE) || (cur_col_ff == COL_LAST)) begin
                  cur_col_in = '0;
                  if (cur_row_ff == ROW_LAST) begin
                     scroll_in = 1'b1;
                     cnt_in    = '0;
                     state_in  = ST_SCROLL;
                  end else begin
                     cur_row_in = cur_row_ff + 1'b1;
                  end
               end else begin
                  cur_col_in = cur_col_ff + 1'b1;
               end
            end
         end
         ST_FETCH: begin
            cell_in  = mem_rdata_ff;
            state_in = ST_DONE;
         end
         ST_SCROLL: begin
            mem_we    = 1'b1;
            mem_waddr = {top_ff, cnt_ff[CW-1:0]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff[CW-1:0] == COL_LAST) begin
               top_in   = (top_ff == ROW_LAST) ? '0 : top_ff + 1'b1;
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_col_in    = ColWidth'(cur_col_ff);
               rsp_row_in    = RowWidth'(cur_row_ff);
               rsp_cell_in   = cell_ff;
               rsp_scroll_in = scroll_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         top_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         top_ff       <= top_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_cmd_ff  <= req_cmd;
         item_char_ff <= req_char_code;
         item_back_ff <= req_back_color;
         item_fore_ff <= req_fore_color;
         item_row_ff  <= req_read_row;
         item_col_ff  <= req_read_col;
      end
      cell_ff       <= cell_in;
      scroll_ff     <= scroll_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= screen_mem[mem_raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_did_scroll = rsp_scroll_ff;

endmodule

// ----- design/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [tcw_pkg::CmdWidth-1:0]       req_cmd,
   input logic [tcw_pkg::CharWidth-1:0]      req_char_code,
   input logic [tcw_pkg::ColorWidth-1:0]     req_back_color,
   input logic [tcw_pkg::ColorWidth-1:0]     req_fore_color,
   input logic [tcw_pkg::RowWidth-1:0]       req_read_row,
   input logic [tcw_pkg::ColWidth-1:0]       req_read_col,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [tcw_pkg::ColWidth-1:0]       rsp_cursor_col,
   input logic [tcw_pkg::RowWidth-1:0]       rsp_cursor_row,
   input logic [tcw_pkg::CellWidth-1:0]      rsp_cell_value,
   input logic                               rsp_did_scroll
);
   import tcw_pkg::*;

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_value)
         && $stable(rsp_cursor_col) && $stable(rsp_cursor_row))
      else $error("stalled result changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("activity straight after reset");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_col) < COLS) && (32'(rsp_cursor_row) < ROWS))
      else $error("cursor outside the screen");

   a_scroll_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_did_scroll |->
         (rsp_cursor_col == '0) && (32'(rsp_cursor_row) == ROWS - 1)
         && (rsp_cell_value == EMPTY_CELL))
      else $error("scroll left the cursor off the last row start");

endmodule

bind text_console_writer tcw_checker #(.COLS(COLS), .ROWS(ROWS)) u_tcw_checker (.*);

// ----- tb/console_checker.sv -----
// ----------------------------------------------------------------------------
// console_checker
// Watches both channels of the text console writer, keeps its own copy of
// the screen and cursor, predicts one result per accepted command and
// compares each result transfer field by field against the oldest one due.
// ----------------------------------------------------------------------------
module console_checker #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [tcw_pkg::CmdWidth-1:0]   req_cmd,
   input  logic [tcw_pkg::CharWidth-1:0]  req_char_code,
   input  logic [tcw_pkg::ColorWidth-1:0] req_back_color,
   input  logic [tcw_pkg::ColorWidth-1:0] req_fore_color,
   input  logic [tcw_pkg::RowWidth-1:0]   req_read_row,
   input  logic [tcw_pkg::ColWidth-1:0]   req_read_col,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [tcw_pkg::ColWidth-1:0]   rsp_cursor_col,
   input  logic [tcw_pkg::RowWidth-1:0]   rsp_cursor_row,
   input  logic [tcw_pkg::CellWidth-1:0]  rsp_cell_value,
   input  logic                           rsp_did_scroll,
   output int unsigned                    mismatches,
   output int unsigned                    outstanding,
   output int unsigned                    results_seen,
   output int unsigned                    scrolls_seen,
   output int unsigned                    reads_seen
);
   import tcw_pkg::*;

   typedef struct packed {
      logic [ColWidth-1:0]  col;
      logic [RowWidth-1:0]  row;
      logic [CellWidth-1:0] cell_value;
      logic                 scrolled;
   } console_result_type;

   logic [CellWidth-1:0] screen [COLS*ROWS];
   int unsigned          cursor_col;
   int unsigned          cursor_row;
   console_result_type   due_results [$];
   console_result_type   want;

   function automatic bit line_feed();
      cursor_col = 0;
      if (cursor_row + 1 >= ROWS) begin
         for (int i = 0; i < COLS*(ROWS-1); i++) screen[i] = screen[i+COLS];
         for (int i = 0; i < COLS; i++) screen[COLS*(ROWS-1)+i] = EMPTY_CELL;
         cursor_row = ROWS - 1;
         return 1'b1;
      end
      cursor_row++;
      return 1'b0;
   endfunction

   function automatic console_result_type console_apply(
      input logic [CmdWidth-1:0]   cmd,
      input logic [CharWidth-1:0]  ch,
      input logic [ColorWidth-1:0] bg,
      input logic [ColorWidth-1:0] fg,
      input logic [RowWidth-1:0]   rr,
      input logic [ColWidth-1:0]   rc
   );
      console_result_type r;
      r.cell_value = EMPTY_CELL;
      r.scrolled   = 1'b0;
      if (cmd == CMD_READ) begin
         if (rr < ROWS && rc < COLS) r.cell_value = screen[rr*COLS + rc];
      end else if (ch == CH_NEWLINE) begin
         r.scrolled = line_feed();
      end else if (ch == CH_BACKSPACE) begin
         if (cursor_col > 0) begin
            cursor_col--;
         end else if (cursor_row > 0) begin
            cursor_col = COLS - 1;
            cursor_row--;
         end
         screen[cursor_row*COLS + cursor_col] = BLANK_CELL;
      end else begin
         screen[cursor_row*COLS + cursor_col] = {bg, fg, ch};
         if (cursor_col + 1 >= COLS) r.scrolled = line_feed();
         else cursor_col++;
      end
      r.col = cursor_col[ColWidth-1:0];
      r.row = cursor_row[RowWidth-1:0];
      return r;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLS*ROWS; i++) screen[i] = EMPTY_CELL;
         cursor_col = 0;
         cursor_row = 0;
         due_results.delete();
         mismatches   = 0;
         results_seen = 0;
         scrolls_seen = 0;
         reads_seen   = 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, %s %0d %0d %h %0b",
                        $time, "got col/row/cell/scroll", rsp_cursor_col,
                        rsp_cursor_row, rsp_cell_value, rsp_did_scroll);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               check_field("cursor_col", want.col, rsp_cursor_col);
               check_field("cursor_row", want.row, rsp_cursor_row);
               check_field("cell_value", want.cell_value, rsp_cell_value);
               check_field("did_scroll", want.scrolled, rsp_did_scroll);
               results_seen++;
            end
         end
         if (req_valid && !req_stall) begin
            want = console_apply(req_cmd, req_char_code, req_back_color,
                                 req_fore_color, req_read_row, req_read_col);
            due_results.push_back(want);
            if (req_cmd == CMD_READ) reads_seen++;
            if (want.scrolled) scrolls_seen++;
         end
         outstanding <= due_results.size();
      end
   end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the text console writer bench: drives directed and random put and
// read commands with random gaps and result back-pressure, and gives the
// verdict from the mismatch and outstanding counts of the checker beside the block.
// ----------------------------------------------------------------------------
module tb;
   import tcw_pkg::*;

   localparam int COLS            = 80;
   localparam int ROWS            = 25;
   localparam int ITEMS           = 1500;
   localparam int HOLD_OFF_CYCLES = 300;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CmdWidth-1:0]   req_cmd;
   logic [CharWidth-1:0]  req_char_code;
   logic [ColorWidth-1:0] req_back_color;
   logic [ColorWidth-1:0] req_fore_color;
   logic [RowWidth-1:0]   req_read_row;
   logic [ColWidth-1:0]   req_read_col;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ColWidth-1:0]   rsp_cursor_col;
   logic [RowWidth-1:0]   rsp_cursor_row;
   logic [CellWidth-1:0]  rsp_cell_value;
   logic                  rsp_did_scroll;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned results_seen;
   int unsigned scrolls_seen;
   int unsigned reads_seen;

   int unsigned items_sent;
   int unsigned stall_pct;
   bit          burst;
   bit          hold_off_req;
   bit          pressure_done;

   text_console_writer #(.COLS(COLS), .ROWS(ROWS)) dut (.*);

   console_checker #(.COLS(COLS), .ROWS(ROWS)) u_console_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #25_000_000;
      $display("text_console_writer verification failed");
      $finish;
   end

   function automatic int unsigned sender_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [CharWidth-1:0] printable();
      logic [CharWidth-1:0] c;
      do c = CharWidth'($urandom_range(0, 255));
      while (c == CH_NEWLINE || c == CH_BACKSPACE);
      return c;
   endfunction

   function automatic logic [ColorWidth-1:0] rand_color();
      return ColorWidth'($urandom_range(0, 15));
   endfunction

   task automatic send_item(input logic [CmdWidth-1:0] cmd, input logic [CharWidth-1:0] ch,
                            input logic [ColorWidth-1:0] bg, input logic [ColorWidth-1:0] fg,
                            input logic [RowWidth-1:0] rr, input logic [ColWidth-1:0] rc);
      int unsigned gap;
      if (items_sent >= ITEMS) return;
      gap = burst ? 0 : sender_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_char_code  <= ch;
      req_back_color <= bg;
      req_fore_color <= fg;
      req_read_row   <= rr;
      req_read_col   <= rc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic put_char(input logic [CharWidth-1:0] ch, input logic [ColorWidth-1:0] bg,
                           input logic [ColorWidth-1:0] fg);
      send_item(CMD_PUT, ch, bg, fg, RowWidth'($urandom_range(0, 31)),
                ColWidth'($urandom_range(0, 127)));
   endtask

   task automatic read_cell(input logic [RowWidth-1:0] rr, input logic [ColWidth-1:0] rc);
      send_item(CMD_READ, CharWidth'($urandom_range(0, 255)), rand_color(),
                rand_color(), rr, rc);
   endtask

   task automatic write_line();
      int unsigned len;
      int unsigned r;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(70, 170) : $urandom_range(0, 30);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 19);
         if (r == 0) put_char(CH_BACKSPACE, rand_color(), rand_color());
         else if (r == 1) read_cell(RowWidth'($urandom_range(0, ROWS-1)),
                                    ColWidth'($urandom_range(0, COLS-1)));
         else put_char(printable(), rand_color(), rand_color());
      end
      put_char(CH_NEWLINE, rand_color(), rand_color());
   endtask

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            if ($urandom_range(0, 99) < 85) repeat ($urandom_range(1, 3)) @(posedge clock);
            else repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   initial begin
      int unsigned kind;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_PUT;
      req_char_code  = '0;
      req_back_color = '0;
      req_fore_color = '0;
      req_read_row   = '0;
      req_read_col   = '0;
      items_sent     = 0;
      stall_pct      = 20;
      burst          = 1'b0;
      hold_off_req   = 1'b0;
      pressure_done  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: cleared screen, range limits, colour extremes, edit cases
      read_cell('0, '0);
      read_cell(RowWidth'(ROWS-1), ColWidth'(COLS-1));
      read_cell(RowWidth'(ROWS), '0);
      read_cell('0, ColWidth'(COLS));
      read_cell(5'd31, 7'd127);
      put_char(CH_BACKSPACE, 4'hF, 4'hF);
      read_cell('0, '0);
      put_char(8'h41, 4'hF, 4'hF);
      put_char(8'h00, 4'h0, 4'h0);
      put_char(8'hFF, 4'hA, 4'h5);
      read_cell('0, '0);
      read_cell('0, 7'd2);
      put_char(CH_BACKSPACE, 4'h3, 4'hC);
      read_cell('0, 7'd2);
      put_char(CH_NEWLINE, 4'h0, 4'h0);
      put_char(CH_BACKSPACE, 4'h0, 4'h0);
      read_cell('0, ColWidth'(COLS-1));
      put_char(8'h7E, 4'h5, 4'hA);
      read_cell('0, ColWidth'(COLS-1));
      put_char(CH_NEWLINE, 4'hF, 4'hF);

      while (items_sent < ITEMS) begin
         burst = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 15;
            2: stall_pct = 40;
            default: stall_pct = 70;
         endcase
         if (!pressure_done && items_sent >= ITEMS/2) begin
            pressure_done = 1'b1;
            burst         = 1'b1;
            hold_off_req  = 1'b1;
            repeat (40) put_char(printable(), rand_color(), rand_color());
         end
         kind = $urandom_range(0, 9);
         case (kind)
            7: repeat ($urandom_range(10, 40))
                  send_item(CmdWidth'($urandom_range(0, 1)),
                            ($urandom_range(0, 3) == 0) ? CH_BACKSPACE :
                            ($urandom_range(0, 3) == 0) ? CH_NEWLINE :
                            CharWidth'($urandom_range(0, 255)),
                            rand_color(), rand_color(),
                            RowWidth'($urandom_range(0, 31)),
                            ColWidth'($urandom_range(0, 127)));
            8: repeat ($urandom_range(5, 30))
                  put_char(CH_NEWLINE, rand_color(), rand_color());
            9: begin
               put_char(CH_NEWLINE, 4'h0, 4'h0);
               repeat ($urandom_range(1, 100)) begin
                  if ($urandom_range(0, 4) == 0)
                     read_cell(RowWidth'($urandom_range(0, ROWS-1)),
                               ColWidth'($urandom_range(0, COLS-1)));
                  else
                     put_char(CH_BACKSPACE, rand_color(), rand_color());
               end
            end
            default: repeat ($urandom_range(1, 6)) write_line();
         endcase
      end
      req_valid <= 1'b0;

      do @(posedge clock);
      while (outstanding != 0);
      repeat (COLS + 10) @(posedge clock);

      $display("Ran %0d commands (%0d cell reads) with %0d results checked.",
               items_sent, reads_seen, results_seen);
      $display("Screen scrolled %0d times; one receiver hold-off of %0d cycles.",
               scrolls_seen, HOLD_OFF_CYCLES);
      if (mismatches == 0 && outstanding == 0) begin
         $display("text_console_writer verification clean");
      end else begin
         $display("text_console_writer verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/tcw_pkg.sv
design/text_console_writer.sv
design/tcw_checker.sv
tb/console_checker.sv
tb/tb.sv
